// ----- hw/rtl/dns_query_retry_controller_assert.svh -----
// Assertion macros shared by the DNS query retry controller RTL.
// Plain concurrent assertions on a clock with an active-low reset.
`ifndef DNS_QUERY_RETRY_CONTROLLER_ASSERT_SVH
`define DNS_QUERY_RETRY_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define DQR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dqr assertion failed");

// Next-cycle implication.
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dqr assertion failed");

`endif

// ----- hw/rtl/dqr_pkg.sv -----
// Shared types and constants of the DNS query retry controller.
// No dependencies.
`timescale 1ns / 1ps

package dqr_pkg;

    localparam int MAX_SERVERS = 3;
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = 32;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_WRITE = 2'd1,
        OP_TIMER = 2'd2,
        OP_REPLY = 2'd3
    } t_op;

    localparam logic [2:0] ST_ANSWER   = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_NOANSWER = 3'd2;
    localparam logic [2:0] ST_RCODE    = 3'd3;
    localparam logic [2:0] ST_GENFAIL  = 3'd4;

    localparam logic [2:0] CFG_SERVER_COUNT = 3'd0;
    localparam logic [2:0] CFG_SERVER_ADDR0 = 3'd1;
    localparam logic [2:0] CFG_SERVER_ADDR1 = 3'd2;
    localparam logic [2:0] CFG_SERVER_ADDR2 = 3'd3;
    localparam logic [2:0] CFG_BASE_RETX    = 3'd4;
    localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd5;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef logic [MAX_SERVERS-1:0][ADDR_W-1:0] t_addr_vec;

    // Outcome of checking one reply header against the server table.
    typedef struct packed {
        logic              hit;        // source matched a server in use
        logic [SLOT_W-1:0] slot;       // first matching server
        logic              answer_ok;  // good header, rcode 0, answers present
        logic              take_now;   // good header from an authoritative server
        logic [2:0]        err;        // status to report if this reply ends the query
    } t_reply_chk;

endpackage

// ----- hw/rtl/dns_query_retry_controller.sv -----
// DNS query retry controller top level: event input register, control
// state, result register. Depends on dqr_pkg, dqr_reply_check and the assert macros.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------
//  event in | i_in_valid  | o_in_stall  | i_op .. i_answer_count
//  result   | o_out_valid | i_out_stall | o_send_now .. o_stray_reply
//  config   | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data
//
// Every event beat gives one result beat: the input register takes it, and the
// control logic then writes the result register. One beat per cycle is sustained
// while i_out_stall is low; the single control update sits between the input
// register and the result register.
// Reset is synchronous and active low; no clearing pass.
// A stall on the result side holds the result register and then the input register.
`timescale 1ns / 1ps

module dns_query_retry_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // events
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic        i_io_ok,
    input  logic [15:0] i_query_id,
    input  logic [31:0] i_source_addr,
    input  logic [15:0] i_reply_id,
    input  logic        i_truncated,
    input  logic        i_is_response,
    input  logic        i_recursion_avail,
    input  logic        i_authoritative,
    input  logic [15:0] i_question_count,
    input  logic [3:0]  i_response_code,
    input  logic [15:0] i_answer_count,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_now,
    output logic [1:0]  o_server_slot,
    output logic        o_arm_timer,
    output logic [15:0] o_timer_ticks,
    output logic        o_finished,
    output logic [2:0]  o_status,
    output logic [3:0]  o_server_rcode,
    output logic        o_stray_reply
);
    import dqr_pkg::*;

    `include "dns_query_retry_controller_assert.svh"

    // configuration registers
    logic [1:0]  r_server_count;
    t_addr_vec   r_server_addr;
    logic [15:0] r_base_retx;
    logic [7:0]  r_retry_limit;

    // control state
    logic                   r_busy, n_busy;
    logic                   r_sending_en, n_sending_en;
    logic                   r_first_fatal, n_first_fatal;
    logic [15:0]            r_interval, n_interval;
    logic [7:0]             r_retries_left, n_retries_left;
    logic [MAX_SERVERS-1:0] r_active, n_active;
    logic [SLOT_W-1:0]      r_next_server, n_next_server;
    logic [15:0]            r_pending_id, n_pending_id;

    // input register
    logic        r_in_valid;
    t_op         r_in_op;
    logic        r_in_io_ok;
    logic [15:0] r_in_query_id;
    logic [31:0] r_in_source_addr;
    logic [15:0] r_in_reply_id;
    logic        r_in_truncated;
    logic        r_in_is_response;
    logic        r_in_recursion_avail;
    logic        r_in_authoritative;
    logic [15:0] r_in_question_count;
    logic [3:0]  r_in_response_code;
    logic [15:0] r_in_answer_count;

    // result register
    logic        r_out_valid;
    logic        r_send_now, n_send_now;
    logic [1:0]  r_server_slot, n_server_slot;
    logic        r_arm_timer, n_arm_timer;
    logic [15:0] r_timer_ticks, n_timer_ticks;
    logic        r_finished, n_finished;
    logic [2:0]  r_status, n_status;
    logic [3:0]  r_server_rcode, n_server_rcode;
    logic        r_stray_reply, n_stray_reply;

    logic              w_adv;
    logic              w_in_load;
    logic [SLOT_W-1:0] w_cnt;
    t_reply_chk        w_chk;
    logic              w_fin;
    logic [2:0]        w_fin_st;
    logic [3:0]        w_fin_rc;
    logic [SLOT_W-1:0] w_nxt;
    logic [16:0]       w_dbl;

    assign w_adv      = !r_out_valid || !i_out_stall;
    // an empty input register takes a beat even while the result side waits
    assign w_in_load  = !r_in_valid || w_adv;
    assign o_in_stall = !w_in_load;

    // server count clamped into 1..MAX_SERVERS
    always_comb begin
        if (r_server_count == '0) begin
            w_cnt = SLOT_W'(1);
        end else if (int'(r_server_count) > MAX_SERVERS) begin
            w_cnt = SLOT_W'(MAX_SERVERS);
        end else begin
            w_cnt = r_server_count;
        end
    end

    dqr_reply_check u_reply_check (
        .i_server_addr     (r_server_addr),
        .i_server_cnt      (w_cnt),
        .i_source_addr     (r_in_source_addr),
        .i_truncated       (r_in_truncated),
        .i_is_response     (r_in_is_response),
        .i_recursion_avail (r_in_recursion_avail),
        .i_authoritative   (r_in_authoritative),
        .i_question_count  (r_in_question_count),
        .i_response_code   (r_in_response_code),
        .i_answer_count    (r_in_answer_count),
        .o_chk             (w_chk)
    );

    always_comb begin
        n_busy         = r_busy;
        n_sending_en   = r_sending_en;
        n_first_fatal  = r_first_fatal;
        n_interval     = r_interval;
        n_retries_left = r_retries_left;
        n_active       = r_active;
        n_next_server  = r_next_server;
        n_pending_id   = r_pending_id;

        n_send_now     = 1'b0;
        n_server_slot  = '0;
        n_arm_timer    = 1'b0;
        n_timer_ticks  = '0;
        n_stray_reply  = 1'b0;

        w_fin    = 1'b0;
        w_fin_st = ST_GENFAIL;
        w_fin_rc = '0;
        w_nxt    = r_next_server + SLOT_W'(1);
        w_dbl    = {r_interval, 1'b0};

        unique case (r_in_op)
            OP_START: begin
                if (!r_in_io_ok) begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_GENFAIL;
                end else begin
                    n_busy         = 1'b1;
                    n_sending_en   = 1'b1;
                    n_first_fatal  = 1'b1;
                    n_interval     = r_base_retx;
                    n_retries_left = r_retry_limit;
                    for (int i = 0; i < MAX_SERVERS; i++) begin
                        n_active[i] = (i < int'(w_cnt));
                    end
                    n_next_server  = '0;
                    n_pending_id   = r_in_query_id;
                    n_arm_timer    = 1'b1;
                    n_timer_ticks  = r_base_retx;
                end
            end
            OP_WRITE: begin
                if (r_busy && r_sending_en) begin
                    if ((int'(r_next_server) < MAX_SERVERS) && r_active[r_next_server] &&
                        !r_in_io_ok) begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_TIMEOUT;
                    end else begin
                        if ((int'(r_next_server) < MAX_SERVERS) && r_active[r_next_server]) begin
                            n_send_now    = 1'b1;
                            n_server_slot = r_next_server;
                        end
                        n_next_server = w_nxt;
                        // last slot of the round: arm the retransmit timer
                        if (w_nxt >= w_cnt) begin
                            n_next_server = '0;
                            n_sending_en  = 1'b0;
                            n_first_fatal = 1'b0;
                            n_arm_timer   = 1'b1;
                            n_timer_ticks = r_interval;
                        end
                    end
                end
            end
            OP_TIMER: begin
                if (r_busy) begin
                    if (r_first_fatal || (r_retries_left <= 8'd1)) begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_TIMEOUT;
                    end else begin
                        n_retries_left = r_retries_left - 8'd1;
                        n_interval     = w_dbl[16] ? TICKS_MAX : w_dbl[15:0];
                        n_sending_en   = 1'b1;
                        n_arm_timer    = 1'b1;
                        n_timer_ticks  = n_interval;
                    end
                end
            end
            OP_REPLY: begin
                if (r_busy) begin
                    if (!r_in_io_ok) begin
                        w_fin    = 1'b1;
                        w_fin_st = ST_TIMEOUT;
                    end else if (!w_chk.hit) begin
                        n_stray_reply = 1'b1;
                    end else if (r_in_reply_id == r_pending_id) begin
                        w_fin_st = w_chk.err;
                        w_fin_rc = r_in_response_code;
                        if (w_chk.answer_ok || w_chk.take_now) begin
                            w_fin = 1'b1;
                        end else begin
                            // strike the failing server
                            n_active[w_chk.slot] = 1'b0;
                            w_fin = (n_active == '0);
                        end
                    end
                end
            end
            default: ;
        endcase

        if (w_fin) begin
            n_busy        = 1'b0;
            n_sending_en  = 1'b0;
            n_first_fatal = 1'b0;
        end
        n_finished     = w_fin;
        n_status       = w_fin ? w_fin_st : 3'd0;
        n_server_rcode = (w_fin && (w_fin_st == ST_RCODE)) ? w_fin_rc : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count   <= 2'd1;
            r_server_addr    <= '0;
            r_base_retx      <= 16'd5;
            r_retry_limit    <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SERVER_COUNT: r_server_count   <= i_cfg_data[1:0];
                CFG_SERVER_ADDR0: r_server_addr[0] <= i_cfg_data;
                CFG_SERVER_ADDR1: r_server_addr[1] <= i_cfg_data;
                CFG_SERVER_ADDR2: r_server_addr[2] <= i_cfg_data;
                CFG_BASE_RETX:    r_base_retx      <= i_cfg_data[15:0];
                CFG_RETRY_LIMIT:  r_retry_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_busy         <= 1'b0;
            r_sending_en   <= 1'b0;
            r_first_fatal  <= 1'b0;
            r_interval     <= '0;
            r_retries_left <= '0;
            r_active       <= '0;
            r_next_server  <= '0;
            r_pending_id   <= '0;
        end else begin
            if (w_in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_busy         <= n_busy;
                    r_sending_en   <= n_sending_en;
                    r_first_fatal  <= n_first_fatal;
                    r_interval     <= n_interval;
                    r_retries_left <= n_retries_left;
                    r_active       <= n_active;
                    r_next_server  <= n_next_server;
                    r_pending_id   <= n_pending_id;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_op              <= t_op'(i_op);
            r_in_io_ok           <= i_io_ok;
            r_in_query_id        <= i_query_id;
            r_in_source_addr     <= i_source_addr;
            r_in_reply_id        <= i_reply_id;
            r_in_truncated       <= i_truncated;
            r_in_is_response     <= i_is_response;
            r_in_recursion_avail <= i_recursion_avail;
            r_in_authoritative   <= i_authoritative;
            r_in_question_count  <= i_question_count;
            r_in_response_code   <= i_response_code;
            r_in_answer_count    <= i_answer_count;
        end
        if (w_adv) begin
            r_send_now           <= n_send_now;
            r_server_slot        <= n_server_slot;
            r_arm_timer          <= n_arm_timer;
            r_timer_ticks        <= n_timer_ticks;
            r_finished           <= n_finished;
            r_status             <= n_status;
            r_server_rcode       <= n_server_rcode;
            r_stray_reply        <= n_stray_reply;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_now     = r_send_now;
    assign o_server_slot  = r_server_slot;
    assign o_arm_timer    = r_arm_timer;
    assign o_timer_ticks  = r_timer_ticks;
    assign o_finished     = r_finished;
    assign o_status       = r_status;
    assign o_server_rcode = r_server_rcode;
    assign o_stray_reply  = r_stray_reply;

    `DQR_ASSERT_NEXT(a_beat_reaches_out, i_clk, i_rst_n, r_in_valid && w_adv, r_out_valid)
    `DQR_ASSERT_NOW(a_idle_not_sending, i_clk, i_rst_n, !r_busy, !r_sending_en && !r_first_fatal)
    `DQR_ASSERT_NOW(a_finish_alone, i_clk, i_rst_n, r_out_valid && r_finished,
        !r_send_now && !r_arm_timer && !r_stray_reply)
    `DQR_ASSERT_NOW(a_rcode_only_st3, i_clk, i_rst_n, r_out_valid && (r_status != ST_RCODE),
        r_server_rcode == 4'd0)

endmodule

// ----- hw/rtl/dqr_reply_check.sv -----
// Reply header check: source server match and header classification.
// Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_reply_check (
    input  dqr_pkg::t_addr_vec          i_server_addr,
    input  logic [dqr_pkg::SLOT_W-1:0]  i_server_cnt,
    input  logic [31:0]                 i_source_addr,
    input  logic                        i_truncated,
    input  logic                        i_is_response,
    input  logic                        i_recursion_avail,
    input  logic                        i_authoritative,
    input  logic [15:0]                 i_question_count,
    input  logic [3:0]                  i_response_code,
    input  logic [15:0]                 i_answer_count,
    output dqr_pkg::t_reply_chk         o_chk
);
    import dqr_pkg::*;

    logic bad;

    always_comb begin
        o_chk.hit  = 1'b0;
        o_chk.slot = '0;
        // walk downward so the lowest matching slot wins
        for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
            if ((i < int'(i_server_cnt)) &&
                ((i_server_addr[i] == '0) || (i_server_addr[i] == i_source_addr))) begin
                o_chk.hit  = 1'b1;
                o_chk.slot = SLOT_W'(i);
            end
        end

        bad = i_truncated || !i_is_response || !i_recursion_avail ||
              (i_question_count != 16'd1);

        o_chk.answer_ok = 1'b0;
        o_chk.take_now  = !bad && i_authoritative;
        if (bad) begin
            o_chk.err = ST_GENFAIL;
        end else if (i_response_code != 4'd0) begin
            o_chk.err = ST_RCODE;
        end else if (i_answer_count == 16'd0) begin
            o_chk.err = ST_NOANSWER;
        end else begin
            o_chk.err       = ST_ANSWER;
            o_chk.answer_ok = 1'b1;
        end
    end

endmodule

// ----- tb/sv/dqr_tb_pkg.sv -----
// Beat types and the scoreboard class of the DNS query retry controller testbench.
// Depends on dqr_pkg; the class tracks query state and checks result beats in order.
`timescale 1ns / 1ps

package dqr_tb_pkg;
    import dqr_pkg::*;

    typedef struct packed {
        t_op         op;
        logic        io_ok;
        logic [15:0] query_id;
        logic [31:0] source_addr;
        logic [15:0] reply_id;
        logic        truncated;
        logic        is_response;
        logic        recursion_avail;
        logic        authoritative;
        logic [15:0] question_count;
        logic [3:0]  response_code;
        logic [15:0] answer_count;
    } dns_event_t;

    typedef struct packed {
        logic        send_now;
        logic [1:0]  server_slot;
        logic        arm_timer;
        logic [15:0] timer_ticks;
        logic        finished;
        logic [2:0]  status;
        logic [3:0]  server_rcode;
        logic        stray_reply;
    } dns_result_t;

    class query_tracker;
        // register copies
        logic [1:0]             server_count;
        logic [31:0]            server_addr [MAX_SERVERS];
        logic [15:0]            base_ticks;
        logic [7:0]             retry_limit;
        // controller state
        logic                   busy;
        logic                   sending;
        logic                   first_fatal;
        logic [15:0]            interval;
        logic [7:0]             retries_left;
        logic [MAX_SERVERS-1:0] active;
        logic [1:0]             next_slot;
        logic [15:0]            pending_id;
        logic [2:0]             last_status;

        dns_result_t            pending_results[$];
        int                     errors;
        int                     checked;

        function new();
            server_count = 2'd1;
            for (int i = 0; i < MAX_SERVERS; i++)
                server_addr[i] = '0;
            base_ticks   = 16'd5;
            retry_limit  = 8'd2;
            busy         = 1'b0;
            sending      = 1'b0;
            first_fatal  = 1'b0;
            interval     = '0;
            retries_left = '0;
            active       = '0;
            next_slot    = '0;
            pending_id   = '0;
            last_status  = ST_GENFAIL;
            errors       = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_SERVER_COUNT: server_count = data[1:0];
                CFG_SERVER_ADDR0: server_addr[0] = data;
                CFG_SERVER_ADDR1: server_addr[1] = data;
                CFG_SERVER_ADDR2: server_addr[2] = data;
                CFG_BASE_RETX:    base_ticks = data[15:0];
                CFG_RETRY_LIMIT:  retry_limit = data[7:0];
                default: ;
            endcase
        endfunction

        function dns_result_t end_query(logic [2:0] st, logic [3:0] rc);
            dns_result_t res;
            res          = '0;
            busy         = 1'b0;
            sending      = 1'b0;
            first_fatal  = 1'b0;
            last_status  = st;
            res.finished = 1'b1;
            res.status   = st;
            res.server_rcode = (st == ST_RCODE) ? rc : 4'd0;
            return res;
        endfunction

        function dns_result_t advance_query(dns_event_t ev);
            dns_result_t res;
            int          cnt;
            int          hit;
            int          i;
            logic [16:0] doubled;
            logic [2:0]  err;
            logic        bad;
            res = '0;
            cnt = (server_count == 2'd0) ? 1 : int'(server_count);

            if (ev.op == OP_START) begin
                if (!ev.io_ok)
                    return end_query(ST_GENFAIL, 4'd0);
                busy         = 1'b1;
                sending      = 1'b1;
                first_fatal  = 1'b1;
                interval     = base_ticks;
                retries_left = retry_limit;
                active       = '0;
                for (i = 0; i < cnt; i++)
                    active[i] = 1'b1;
                next_slot     = '0;
                pending_id    = ev.query_id;
                res.arm_timer = 1'b1;
                res.timer_ticks = interval;
                return res;
            end
            if (!busy)
                return res;

            case (ev.op)
                OP_WRITE: begin
                    if (!sending)
                        return res;
                    if (int'(next_slot) < MAX_SERVERS && active[next_slot]) begin
                        if (!ev.io_ok)
                            return end_query(ST_TIMEOUT, 4'd0);
                        res.send_now    = 1'b1;
                        res.server_slot = next_slot;
                    end
                    next_slot = next_slot + 2'd1;
                    // round over: wait for the retransmit timer
                    if (int'(next_slot) >= cnt) begin
                        next_slot       = '0;
                        sending         = 1'b0;
                        first_fatal     = 1'b0;
                        res.arm_timer   = 1'b1;
                        res.timer_ticks = interval;
                    end
                end
                OP_TIMER: begin
                    if (first_fatal || retries_left <= 8'd1)
                        return end_query(ST_TIMEOUT, 4'd0);
                    retries_left    = retries_left - 8'd1;
                    doubled         = {interval, 1'b0};
                    interval        = doubled[16] ? TICKS_MAX : doubled[15:0];
                    sending         = 1'b1;
                    res.arm_timer   = 1'b1;
                    res.timer_ticks = interval;
                end
                default: begin
                    if (!ev.io_ok)
                        return end_query(ST_TIMEOUT, 4'd0);
                    hit = -1;
                    for (i = 0; i < cnt && hit < 0; i++)
                        if (server_addr[i] == '0 || server_addr[i] == ev.source_addr)
                            hit = i;
                    if (hit < 0) begin
                        res.stray_reply = 1'b1;
                        return res;
                    end
                    if (ev.reply_id != pending_id)
                        return res;
                    err = ST_GENFAIL;
                    bad = ev.truncated || !ev.is_response || !ev.recursion_avail ||
                          ev.question_count != 16'd1;
                    if (!bad) begin
                        if (ev.response_code != 4'd0)
                            err = ST_RCODE;
                        else if (ev.answer_count == 16'd0)
                            err = ST_NOANSWER;
                        else
                            return end_query(ST_ANSWER, 4'd0);
                        // an authoritative verdict ends the query at once
                        if (ev.authoritative)
                            return end_query(err, ev.response_code);
                    end
                    active[hit] = 1'b0;
                    if (active == '0)
                        return end_query(err, ev.response_code);
                end
            endcase
            return res;
        endfunction

        function void note_event(dns_event_t ev);
            pending_results.push_back(advance_query(ev));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] result %0d: %s", $time, checked, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_result(dns_result_t got);
            dns_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no event waiting");
                return;
            end
            want = pending_results.pop_front();
            compare_field("send_now", 32'(got.send_now), 32'(want.send_now));
            compare_field("server_slot", 32'(got.server_slot), 32'(want.server_slot));
            compare_field("arm_timer", 32'(got.arm_timer), 32'(want.arm_timer));
            compare_field("timer_ticks", 32'(got.timer_ticks), 32'(want.timer_ticks));
            compare_field("finished", 32'(got.finished), 32'(want.finished));
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("server_rcode", 32'(got.server_rcode), 32'(want.server_rcode));
            compare_field("stray_reply", 32'(got.stray_reply), 32'(want.stray_reply));
        endtask
    endclass

endpackage

// ----- tb/sv/testbench.sv -----
// Top of the DNS query retry controller testbench: clock, reset, event driver,
// result monitor with back-pressure, watchdog. Depends on dqr_pkg and dqr_tb_pkg.
`timescale 1ns / 1ps

module testbench;
    import dqr_pkg::*;
    import dqr_tb_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_PCT     = 14;
    localparam int DRAIN_CYCLES = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_SERVER_COUNT;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_out_stall = 1'b0;
    dns_event_t  beat_in = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_send_now;
    logic [1:0]  o_server_slot;
    logic        o_arm_timer;
    logic [15:0] o_timer_ticks;
    logic        o_finished;
    logic [2:0]  o_status;
    logic [3:0]  o_server_rcode;
    logic        o_stray_reply;

    query_tracker tracker = new();

    // what the stimulus knows of the current setup
    logic [1:0]  cfg_count = 2'd1;
    logic [31:0] cfg_addr [MAX_SERVERS];
    logic [15:0] cur_id = '0;
    int          sent_total = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    int          next_hold_at = 250;
    int          quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    dns_query_retry_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (beat_in.op),
        .i_io_ok           (beat_in.io_ok),
        .i_query_id        (beat_in.query_id),
        .i_source_addr     (beat_in.source_addr),
        .i_reply_id        (beat_in.reply_id),
        .i_truncated       (beat_in.truncated),
        .i_is_response     (beat_in.is_response),
        .i_recursion_avail (beat_in.recursion_avail),
        .i_authoritative   (beat_in.authoritative),
        .i_question_count  (beat_in.question_count),
        .i_response_code   (beat_in.response_code),
        .i_answer_count    (beat_in.answer_count),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_send_now        (o_send_now),
        .o_server_slot     (o_server_slot),
        .o_arm_timer       (o_arm_timer),
        .o_timer_ticks     (o_timer_ticks),
        .o_finished        (o_finished),
        .o_status          (o_status),
        .o_server_rcode    (o_server_rcode),
        .o_stray_reply     (o_stray_reply)
    );

    function automatic int gen_count();
        return (cfg_count == 2'd0) ? 1 : int'(cfg_count);
    endfunction

    function automatic logic [31:0] rand_addr();
        return ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom);
    endfunction

    function automatic dns_event_t noise_event();
        dns_event_t ev;
        ev.op              = t_op'($urandom_range(0, 3));
        ev.io_ok           = 1'($urandom);
        ev.query_id        = 16'($urandom);
        ev.source_addr     = 32'($urandom);
        ev.reply_id        = 16'($urandom);
        ev.truncated       = 1'($urandom);
        ev.is_response     = 1'($urandom);
        ev.recursion_avail = 1'($urandom);
        ev.authoritative   = 1'($urandom);
        ev.question_count  = 16'($urandom);
        ev.response_code   = 4'($urandom);
        ev.answer_count    = 16'($urandom);
        return ev;
    endfunction

    function automatic dns_event_t ctl_event(t_op op, logic io_ok, logic [15:0] id);
        dns_event_t ev;
        ev          = noise_event();
        ev.op       = op;
        ev.io_ok    = io_ok;
        ev.query_id = id;
        return ev;
    endfunction

    function automatic dns_event_t reply_event(logic io_ok, logic [31:0] src,
                                               logic [15:0] id, logic tc, logic qr,
                                               logic ra, logic aa, logic [15:0] qd,
                                               logic [3:0] rc, logic [15:0] an);
        dns_event_t ev;
        ev                 = noise_event();
        ev.op              = OP_REPLY;
        ev.io_ok           = io_ok;
        ev.source_addr     = src;
        ev.reply_id        = id;
        ev.truncated       = tc;
        ev.is_response     = qr;
        ev.recursion_avail = ra;
        ev.authoritative   = aa;
        ev.question_count  = qd;
        ev.response_code   = rc;
        ev.answer_count    = an;
        return ev;
    endfunction

    // mostly well-formed replies from known servers to the live query
    function automatic dns_event_t rand_reply();
        dns_event_t ev;
        int         slot;
        ev    = noise_event();
        ev.op = OP_REPLY;
        ev.io_ok = ($urandom_range(0, 39) != 0);
        slot  = $urandom_range(0, gen_count() - 1);
        if ($urandom_range(0, 9) != 0 && cfg_addr[slot] != '0)
            ev.source_addr = cfg_addr[slot];
        if ($urandom_range(0, 11) != 0)
            ev.reply_id = cur_id;
        ev.truncated       = ($urandom_range(0, 9) == 0);
        ev.is_response     = ($urandom_range(0, 11) != 0);
        ev.recursion_avail = ($urandom_range(0, 11) != 0);
        if ($urandom_range(0, 9) != 0)
            ev.question_count = 16'd1;
        if ($urandom_range(0, 9) < 6)
            ev.response_code = 4'd0;
        case ($urandom_range(0, 3))
            0: ev.answer_count = 16'd0;
            1: ev.answer_count = 16'hFFFF;
            default: ;
        endcase
        return ev;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        tracker.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [1:0] cnt, logic [31:0] a0, logic [31:0] a1,
                                logic [31:0] a2, logic [15:0] base, logic [7:0] limit);
        cfg_write(CFG_SERVER_COUNT, 32'(cnt));
        cfg_write(CFG_SERVER_ADDR0, a0);
        cfg_write(CFG_SERVER_ADDR1, a1);
        cfg_write(CFG_SERVER_ADDR2, a2);
        cfg_write(CFG_BASE_RETX, 32'(base));
        cfg_write(CFG_RETRY_LIMIT, 32'(limit));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_count   = cnt;
        cfg_addr[0] = a0;
        cfg_addr[1] = a1;
        cfg_addr[2] = a2;
    endtask

    task automatic random_config();
        logic [15:0] base;
        logic [7:0]  limit;
        case ($urandom_range(0, 3))
            0: base = 16'($urandom_range(0, 8));
            1: base = TICKS_MAX;
            default: base = 16'($urandom);
        endcase
        limit = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        apply_config(2'($urandom), rand_addr(), rand_addr(), rand_addr(), base, limit);
    endtask

    // holds the beat until the block takes it
    task automatic send_event(dns_event_t ev);
        while ((sent_total < 500 || sent_total >= 700) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        beat_in    <= ev;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        tracker.note_event(ev);
        if (ev.op == OP_START && ev.io_ok)
            cur_id = ev.query_id;
        sent_total++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one query: start, a few rounds of sends, each closed by a timeout or replies
    task automatic run_query();
        int rounds;
        int n;
        rounds = $urandom_range(1, 5);
        send_event(ctl_event(OP_START, $urandom_range(0, 24) != 0, 16'($urandom)));
        for (int r = 0; r < rounds; r++) begin
            n = gen_count() + int'($urandom_range(0, 7) == 0);
            for (int w = 0; w < n; w++)
                send_event(ctl_event(OP_WRITE, $urandom_range(0, 39) != 0, 16'($urandom)));
            if ($urandom_range(0, 9) < 5)
                send_event(ctl_event(OP_TIMER, 1'($urandom), 16'($urandom)));
            else
                repeat ($urandom_range(1, 3)) send_event(rand_reply());
            if ($urandom_range(0, 19) == 0)
                send_event(noise_event());
        end
    endtask

    task automatic random_phase(int target);
        int stop_at;
        stop_at = sent_total + target;
        while (sent_total < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_event(noise_event());
            else
                run_query();
        end
        wait_drained();
    endtask

    task automatic directed_phase();
        apply_config(2'd2, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0, 16'h8000, 8'd3);
        // events while idle change nothing
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(ctl_event(OP_TIMER, 1'b1, 16'hFFFF));
        send_event(reply_event(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                               16'hFFFF, 4'hF, 16'hFFFF));
        send_event(ctl_event(OP_START, 1'b0, 16'h5555));
        send_event(ctl_event(OP_START, 1'b1, 16'hFFFF));
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(reply_event(1'b1, 32'h1234_5678, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'd1));
        send_event(reply_event(1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'd1));
        // doubling 0x8000 saturates
        send_event(ctl_event(OP_TIMER, 1'b1, 16'h0));
        send_event(ctl_event(OP_WRITE, 1'b0, 16'h0));
        send_event(ctl_event(OP_START, 1'b1, 16'h0000));
        send_event(ctl_event(OP_START, 1'b1, 16'h0000));
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(ctl_event(OP_WRITE, 1'b1, 16'h0));
        send_event(reply_event(1'b1, 32'h0A00_0001, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1,
                               16'd1, 4'd5, 16'd0));
        send_event(ctl_event(OP_START, 1'b1, 16'h1234));
        send_event(reply_event(1'b1, 32'hFFFF_FFFF, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'd1));
        send_event(reply_event(1'b1, 32'h0A00_0001, 16'h1234, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'd0));
        // timeout before the first round is over
        send_event(ctl_event(OP_START, 1'b1, 16'h0001));
        send_event(ctl_event(OP_TIMER, 1'b1, 16'h0));
        send_event(ctl_event(OP_START, 1'b1, 16'h00AB));
        send_event(reply_event(1'b0, 32'hFFFF_FFFF, 16'h00AB, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'd1));
        send_event(ctl_event(OP_START, 1'b1, 16'h7777));
        send_event(reply_event(1'b1, 32'hFFFF_FFFF, 16'h7777, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'hFFFF));
        send_event(reply_event(1'b1, 32'hFFFF_FFFF, 16'h7777, 1'b0, 1'b1, 1'b1, 1'b0,
                               16'd1, 4'd0, 16'hFFFF));
        wait_drained();
    endtask

    // result monitor; also drives back-pressure, with a long hold now and then
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result({o_send_now, o_server_slot, o_arm_timer, o_timer_ticks,
                                  o_finished, o_status, o_server_rcode, o_stray_reply});
            results_seen++;
        end
        if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 800;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (results_seen >= 500 && results_seen < 700) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_SERVERS; i++)
            cfg_addr[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_phase();
        apply_config(2'd1, 32'h0, 32'h0, 32'h0, 16'd1, 8'd1);
        random_phase(300);
        apply_config(2'd3, 32'hFFFF_FFFF, 32'h0000_0001, rand_addr(), TICKS_MAX, 8'hFF);
        random_phase(250);
        // count 0 acts as one server; zero interval and zero retry limit
        apply_config(2'd0, rand_addr(), rand_addr(), rand_addr(), 16'd0, 8'd0);
        random_phase(200);
        repeat (3) begin
            random_config();
            random_phase(200);
        end

        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- dns_query_retry_controller.f -----
+incdir+hw/rtl
hw/rtl/dqr_pkg.sv
hw/rtl/dqr_reply_check.sv
hw/rtl/dns_query_retry_controller.sv
tb/sv/dqr_tb_pkg.sv
tb/sv/testbench.sv
